[hw/rtl/sobel_pkg.sv]
// shared types and constants for the sobel edge magnitude block
// no dependencies
`timescale 1ns / 1ps

package sobel_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4095;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = 12;
	localparam int CFG_W      = 12;
	localparam int PIX_W      = 8;
	localparam int GRAD_W     = 11;
	localparam int SQ_W       = 21;
	localparam int ROOT_STEPS = 8;

	localparam logic [15:0] W_RED   = 16'd19595;
	localparam logic [15:0] W_GREEN = 16'd38470;
	localparam logic [15:0] W_BLUE  = 16'd7471;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_GRAY   = 2'd2,
		REG_NONE   = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SUM,
		S_SQX,
		S_SQY,
		S_ROOT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic mul;
		logic sum;
		logic sqx;
		logic sqy;
		logic root_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic interior;
		logic root_done;
		logic out_free;
	} status_t;

endpackage

[hw/rtl/sobel_if.sv]
// stream interfaces for pixel requests and magnitude results
// depends on sobel_pkg
`timescale 1ns / 1ps

interface sobel_pix_if;
	logic                       valid;
	logic                       ready;
	logic [sobel_pkg::PIX_W-1:0] red;
	logic [sobel_pkg::PIX_W-1:0] green;
	logic [sobel_pkg::PIX_W-1:0] blue;
	modport source (output valid, red, green, blue, input ready);
	modport sink   (input valid, red, green, blue, output ready);
endinterface

interface sobel_mag_if;
	logic                       valid;
	logic                       ready;
	logic [sobel_pkg::PIX_W-1:0] edge_magnitude;
	logic                       last_of_frame;
	modport source (output valid, edge_magnitude, last_of_frame, input ready);
	modport sink   (input valid, edge_magnitude, last_of_frame, output ready);
endinterface

[hw/rtl/sobel_ram.sv]
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module sobel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[hw/rtl/sobel_ctrl.sv]
// controller state machine sequencing one pixel through the datapath
// depends on sobel_pkg
`timescale 1ns / 1ps

module sobel_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sobel_pkg::status_t status,
	output sobel_pkg::cmd_t    cmd
);
	import sobel_pkg::*;

	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_next = S_MUL;
			S_MUL:  state_next = S_SUM;
			S_SUM:  state_next = status.interior ? S_SQX : S_IDLE;
			S_SQX:  state_next = S_SQY;
			S_SQY:  state_next = S_ROOT;
			S_ROOT: if (status.root_done) state_next = S_OUT;
			S_OUT:  if (status.out_free) state_next = S_IDLE;
			default: state_next = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_MUL:  cmd.mul = 1'b1;
			S_SUM:  cmd.sum = 1'b1;
			S_SQX:  cmd.sqx = 1'b1;
			S_SQY:  cmd.sqy = 1'b1;
			S_ROOT: cmd.root_step = 1'b1;
			S_OUT:  cmd.load_out = status.out_free;
			default: ;
		endcase
	end
endmodule

[hw/rtl/sobel_dp.sv]
// datapath: gray conversion, line stores, window, gradients, square root
// depends on sobel_pkg and sobel_ram
`timescale 1ns / 1ps

module sobel_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sobel_pkg::cmd_t                 cmd,
	output sobel_pkg::status_t              status,
	input  logic [sobel_pkg::PIX_W-1:0]     red,
	input  logic [sobel_pkg::PIX_W-1:0]     green,
	input  logic [sobel_pkg::PIX_W-1:0]     blue,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [sobel_pkg::CFG_W-1:0]     cfg_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sobel_pkg::PIX_W-1:0]     out_mag,
	output logic                            out_last
);
	import sobel_pkg::*;

	logic [CFG_W-1:0] width_q, height_q;
	logic             gray_mode_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] w_last;
	logic [ROW_W-1:0] h_last;

	logic [PIX_W-1:0] red_q, green_q, blue_q;
	logic [PIX_W-1:0] up_rd, mid_rd, up_q, mid_q;
	logic [23:0]      pr_q, pg_q, pb_q;
	logic [23:0]      gsum;
	logic [PIX_W-1:0] gray;
	logic [PIX_W-1:0] w0_q [3];
	logic [PIX_W-1:0] w1_q [3];
	logic signed [GRAD_W-1:0] e00, e10, e20, e01, e21, eu, em, eg;
	logic signed [GRAD_W-1:0] gx, gy, gx_q, gy_q;
	logic [SQ_W-1:0]  sqx_q, sq_sum;
	logic             last_q, big_q, out_valid_q;
	logic [16:0]      rem_q;
	logic [15:0]      root_q, bit_q, trial;
	logic [2:0]       step_q;
	logic [PIX_W-1:0] mag_q;
	logic             out_last_q;

	// last column and row of the effective frame after clamping
	always_comb begin
		if (width_q < CFG_W'(3)) w_last = COL_W'(2);
		else if (width_q > CFG_W'(MAX_WIDTH)) w_last = COL_W'(MAX_WIDTH - 1);
		else w_last = COL_W'(width_q - CFG_W'(1));
		if (height_q < CFG_W'(3)) h_last = ROW_W'(2);
		else h_last = height_q - ROW_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= CFG_W'(640);
			height_q    <= CFG_W'(480);
			gray_mode_q <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				REG_WIDTH:  width_q <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_GRAY:   gray_mode_q <= cfg_data[0];
				REG_NONE:   ;
				default:    ;
			endcase
			if (cfg_index_t'(cfg_index) != REG_NONE) begin
				col_q <= '0;
				row_q <= '0;
			end
		end else if (cmd.sum) begin
			if (col_q >= w_last) begin
				col_q <= '0;
				row_q <= (row_q >= h_last) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_up_ram (
		.clk(clk), .we(cmd.sum), .addr(col_q), .wdata(mid_q), .rdata(up_rd)
	);
	sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_ram (
		.clk(clk), .we(cmd.sum), .addr(col_q), .wdata(gray), .rdata(mid_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
		end
		if (cmd.mul) begin
			up_q  <= up_rd;
			mid_q <= mid_rd;
			pr_q  <= 24'(W_RED) * 24'(red_q);
			pg_q  <= 24'(W_GREEN) * 24'(green_q);
			pb_q  <= 24'(W_BLUE) * 24'(blue_q);
		end
	end

	assign gsum = pr_q + pg_q + pb_q;
	assign gray = gray_mode_q ? red_q : gsum[23:16];

	assign e00 = GRAD_W'(w0_q[0]);
	assign e10 = GRAD_W'(w0_q[1]);
	assign e20 = GRAD_W'(w0_q[2]);
	assign e01 = GRAD_W'(w1_q[0]);
	assign e21 = GRAD_W'(w1_q[2]);
	assign eu  = GRAD_W'(up_q);
	assign em  = GRAD_W'(mid_q);
	assign eg  = GRAD_W'(gray);
	assign gx  = (eu - e00) + ((em - e10) <<< 1) + (eg - e20);
	assign gy  = (e20 + (e21 <<< 1) + eg) - (e00 + (e01 <<< 1) + eu);

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			gx_q   <= gx;
			gy_q   <= gy;
			last_q <= (row_q >= h_last) && (col_q >= w_last);
			w0_q   <= w1_q;
			w1_q[0] <= up_q;
			w1_q[1] <= mid_q;
			w1_q[2] <= gray;
		end
		if (cmd.sqx) begin
			sqx_q <= SQ_W'($unsigned((2*GRAD_W)'(gx_q) * (2*GRAD_W)'(gx_q)));
		end
	end

	assign sq_sum = sqx_q + SQ_W'($unsigned((2*GRAD_W)'(gy_q) * (2*GRAD_W)'(gy_q)));
	assign trial  = root_q + bit_q;

	// digit-by-digit root of the low 16 bits, larger sums saturate
	always_ff @(posedge clk) begin
		if (cmd.sqy) begin
			big_q  <= |sq_sum[SQ_W-1:16];
			rem_q  <= {1'b0, sq_sum[15:0]};
			root_q <= '0;
			bit_q  <= 16'h4000;
			step_q <= '0;
		end else if (cmd.root_step) begin
			if (rem_q >= {1'b0, trial}) begin
				rem_q  <= rem_q - {1'b0, trial};
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q  <= bit_q >> 2;
			step_q <= step_q + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			mag_q      <= big_q ? 8'hff : root_q[7:0];
			out_last_q <= last_q;
		end
	end

	assign status.interior  = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
	assign status.root_done = (step_q == 3'(ROOT_STEPS - 1));
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_mag   = mag_q;
	assign out_last  = out_last_q;
endmodule

[hw/rtl/sobel_edge_magnitude_top.sv]
// channel  dir  payload                         request
// pix      in   red, green, blue (8b each)      valid && ready
// mag      out  edge_magnitude (8b), last_of_frame  valid && ready
// cfg      in   cfg_we, cfg_index (2b), cfg_data (12b), no handshake
//
// a border pixel passes through capture, the gray multiply and the sum; an interior one
// also runs the two squaring steps, the 8-step root loop and the output load
// a finished result waits in the output register while the next pixel runs
// arst_n clears control state and restores 640x480 color mode
// a write to width, height or gray restarts the frame, line store contents are kept
// depends on sobel_pkg, sobel_if, sobel_ctrl, sobel_dp, sobel_ram
`timescale 1ns / 1ps

module sobel_edge_magnitude_top (
	input  logic                        clk,
	input  logic                        arst_n,
	sobel_pix_if.sink                   pix,
	sobel_mag_if.source                 mag,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [sobel_pkg::CFG_W-1:0] cfg_data
);
	import sobel_pkg::*;

	cmd_t    cmd;
	status_t status;

	sobel_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(pix.valid), .in_ready(pix.ready),
		.status(status), .cmd(cmd)
	);

	sobel_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.red(pix.red), .green(pix.green), .blue(pix.blue),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(mag.valid), .out_ready(mag.ready),
		.out_mag(mag.edge_magnitude), .out_last(mag.last_of_frame)
	);
endmodule

[hw/rtl/sobel_chk.sv]
// port-level checker for the sobel edge magnitude block, bound to the top
// depends on sobel_edge_magnitude_top
`timescale 1ns / 1ps

module sobel_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_mag,
	input logic       out_last
);
	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// one pixel in flight at a time
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("pixel accepted while previous pixel in flight");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_acc, 1) && !$past(in_acc, 2))
		else $error("result too soon after request");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_mag) && $stable(out_last))
		else $error("stalled result changed");
endmodule

bind sobel_edge_magnitude_top sobel_chk u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(pix.valid), .in_ready(pix.ready),
	.out_valid(mag.valid), .out_ready(mag.ready),
	.out_mag(mag.edge_magnitude), .out_last(mag.last_of_frame)
);

[tb/sobel_edge_magnitude_checker.sv]
// edge magnitude predictor and scoreboard: watches the pixel, result and register ports
// depends on sobel_pkg and sobel_if
`timescale 1ns / 1ps

module sobel_edge_magnitude_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	sobel_pix_if                        pix,
	sobel_mag_if                        mag,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [sobel_pkg::CFG_W-1:0] cfg_data,
	output int                          failures,
	output int                          pending
);
	import sobel_pkg::*;

	typedef struct {
		logic [7:0] magnitude;
		logic       last;
	} edge_result_t;

	edge_result_t edge_q[$];

	logic [7:0]  upper_row [MAX_WIDTH];
	logic [7:0]  middle_row[MAX_WIDTH];
	logic [7:0]  left_col[3];
	logic [7:0]  mid_col[3];
	int unsigned col_pos;
	int unsigned row_pos;
	logic [11:0] frame_width;
	logic [11:0] frame_height;
	logic        gray_mode;

	initial begin
		failures = 0;
		pending  = 0;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			upper_row[i]  = '0;
			middle_row[i] = '0;
		end
		for (int k = 0; k < 3; k++) begin
			left_col[k] = '0;
			mid_col[k]  = '0;
		end
	end

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		failures++;
	endtask

	function automatic logic [7:0] root_saturated(input int unsigned sum);
		logic [7:0] root;
		logic [7:0] trial;
		root = '0;
		if (sum >= 65025)
			return 8'd255;
		for (int b = 7; b >= 0; b--) begin
			trial = root | (8'd1 << b);
			if (int'(trial) * int'(trial) <= sum)
				root = trial;
		end
		return root;
	endfunction

	function automatic int unsigned clamp(input logic [11:0] v, input int unsigned hi);
		if (v < 3)
			return 3;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic predict_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int unsigned  w;
		int unsigned  h;
		int unsigned  idx;
		int           gray;
		int           top;
		int           mid;
		int           gx;
		int           gy;
		edge_result_t res;
		w   = clamp(frame_width, MAX_WIDTH);
		h   = clamp(frame_height, MAX_HEIGHT);
		idx = col_pos % MAX_WIDTH;
		if (gray_mode)
			gray = r;
		else
			gray = (int'(W_RED) * r + int'(W_GREEN) * g + int'(W_BLUE) * b) >>> 16;
		top = upper_row[idx];
		mid = middle_row[idx];
		if (row_pos >= 2 && col_pos >= 2) begin
			gx = (top - left_col[0]) + 2 * (mid - left_col[1]) + (gray - left_col[2]);
			gy = (left_col[2] + 2 * mid_col[2] + gray) - (left_col[0] + 2 * mid_col[0] + top);
			res.magnitude = root_saturated(gx * gx + gy * gy);
			res.last      = (row_pos >= h - 1) && (col_pos >= w - 1);
			edge_q.push_back(res);
		end
		left_col       = mid_col;
		mid_col[0]     = top[7:0];
		mid_col[1]     = mid[7:0];
		mid_col[2]     = gray[7:0];
		upper_row[idx]  = mid[7:0];
		middle_row[idx] = gray[7:0];
		if (col_pos >= w - 1) begin
			col_pos = 0;
			row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		edge_result_t want;
		if (!arst_n) begin
			frame_width  = 12'd640;
			frame_height = 12'd480;
			gray_mode    = 1'b0;
			col_pos      = 0;
			row_pos      = 0;
			edge_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					REG_WIDTH: begin
						frame_width = cfg_data;
						col_pos = 0;
						row_pos = 0;
					end
					REG_HEIGHT: begin
						frame_height = cfg_data;
						col_pos = 0;
						row_pos = 0;
					end
					REG_GRAY: begin
						gray_mode = cfg_data[0];
						col_pos = 0;
						row_pos = 0;
					end
					default: ;
				endcase
			end
			if (mag.valid && mag.ready) begin
				if (edge_q.size() == 0) begin
					report($sformatf("unexpected result %0d", mag.edge_magnitude));
				end else begin
					want = edge_q.pop_front();
					if (mag.edge_magnitude !== want.magnitude)
						report($sformatf("edge_magnitude %0d, want %0d",
							mag.edge_magnitude, want.magnitude));
					if (mag.last_of_frame !== want.last)
						report($sformatf("last_of_frame %0b, want %0b",
							mag.last_of_frame, want.last));
				end
			end
			if (pix.valid && pix.ready)
				predict_pixel(pix.red, pix.green, pix.blue);
		end
		pending = edge_q.size();
	end

endmodule

[tb/tb_sobel_edge_magnitude_top.sv]
// stimulus and verdict for the sobel edge magnitude block
// depends on sobel_pkg, sobel_if, the block and sobel_edge_magnitude_checker
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude_top;
	import sobel_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             quiet;
	int               failures;
	int               pending;
	int               random_sent;
	int               stall;
	bit               paused_once;

	sobel_pix_if pix ();
	sobel_mag_if mag ();

	sobel_edge_magnitude_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.mag       (mag),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sobel_edge_magnitude_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.mag       (mag),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.failures  (failures),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side stalls in bursts until the quiet tail
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag.ready <= 1'b0;
			stall     <= 0;
		end else if (quiet) begin
			mag.ready <= 1'b1;
		end else if (stall != 0) begin
			stall <= stall - 1;
			if (stall == 1)
				mag.ready <= 1'b1;
		end else if ($urandom_range(0, 4) == 0) begin
			mag.ready <= 1'b0;
			stall     <= $urandom_range(1, 11);
		end else begin
			mag.ready <= 1'b1;
		end
	end

	function automatic logic [7:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			pix.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.red   <= r;
		pix.green <= g;
		pix.blue  <= b;
		@(negedge clk);
		while (!pix.ready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_pixel(pick_sample(), pick_sample(), pick_sample());
	endtask

	// sender parks and lets the block drain, including border pixels in flight
	task automatic drain();
		pix.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
		input logic gray);
		drain();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_GRAY, {CFG_W'($urandom_range(0, 4095)) & ~CFG_W'(1)} | gray);
		@(posedge clk);
	endtask

	initial begin
		int w;
		int h;
		int frames;
		pix.valid   = 1'b0;
		pix.red     = '0;
		pix.green   = '0;
		pix.blue    = '0;
		cfg_we      = 1'b0;
		cfg_index   = REG_WIDTH;
		cfg_data    = '0;
		quiet       = 1'b0;
		random_sent = 0;
		paused_once = 1'b0;
		arst_n      = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: vertical then horizontal edge in gray mode, saturating
		set_frame(12'd3, 12'd3, 1'b1);
		for (int i = 0; i < 9; i++)
			send_pixel((i % 3 == 2) ? 8'd255 : 8'd0, 8'd0, 8'd0);
		for (int i = 0; i < 9; i++)
			send_pixel((i / 3 == 2) ? 8'd255 : 8'd0, 8'd255, 8'd255);
		// color mode, full white against black
		set_frame(12'd3, 12'd3, 1'b0);
		for (int i = 0; i < 9; i++) begin
			if (i % 2 == 0)
				send_pixel(8'd255, 8'd255, 8'd255);
			else
				send_pixel(8'd0, 8'd0, 8'd0);
		end
		// index past the list is ignored, frame keeps running
		drain();
		write_reg(REG_NONE, 12'hFFF);
		send_random(9);

		// size extremes, including out-of-range values that clamp
		set_frame(12'd2048, 12'd3, 1'($urandom_range(0, 1)));
		send_random(200);
		set_frame(12'd4095, 12'd2, 1'($urandom_range(0, 1)));
		send_random(100);
		set_frame(12'd3, 12'd4095, 1'($urandom_range(0, 1)));
		send_random(150);
		set_frame(12'd0, 12'd1, 1'($urandom_range(0, 1)));
		send_random(20);

		while (random_sent < 600) begin
			if ($urandom_range(0, 9) == 0) begin
				w = $urandom_range(0, 2);
				h = $urandom_range(0, 2);
			end else begin
				w = $urandom_range(3, 12);
				h = $urandom_range(3, 8);
			end
			set_frame(CFG_W'(w), CFG_W'(h), 1'($urandom_range(0, 1)));
			if (w < 3) w = 3;
			if (h < 3) h = 3;
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				if (random_sent > 450)
					quiet = 1'b1;
				if ($urandom_range(0, 4) == 0) begin
					// broken frame, cut short by the next register write
					send_random($urandom_range(1, w * h - 1));
					random_sent += w * h / 2;
					break;
				end
				if (!paused_once && random_sent > 300) begin
					send_random(w + 2);
					drain();
					paused_once = 1'b1;
					send_random(w * h - w - 2);
				end else begin
					send_random(w * h);
				end
				random_sent += w * h;
			end
		end

		pix.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (failures == 0)
			$display("tb_sobel_edge_magnitude_top passed");
		else
			$display("tb_sobel_edge_magnitude_top failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_sobel_edge_magnitude_top failed");
		$finish;
	end

endmodule
